// ----- src/hsvrgb_pkg.sv -----
// Constants shared by the HSV to RGB converter.
// No dependencies; imported by hsv_to_rgb_converter_unit.
`default_nettype none
package hsvrgb_pkg;

  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned IN_W          = 24;
  localparam int unsigned CH_W          = 8;
  localparam int unsigned IN_TDATA_W    = 3 * IN_W;
  localparam int unsigned OUT_TDATA_W   = 3 * CH_W;

endpackage
`default_nettype wire

// ----- src/hsv_to_rgb_converter_unit.sv -----
// HSV to RGB converter: stream in, stream out, one pixel per request.
// Slave request tdata (lowest bit up): hue[23:0], saturation[47:24], brightness[71:48],
// each signed with FRAC_BITS fraction bits. Master request tdata: red[7:0], green[15:8],
// blue[23:16], each rounded to nearest.
// Throughput: one pixel per clock while the output is not stalled. The result passes
// through six register stages: clip, hue times six, s*f and v*(1-s) multipliers,
// v*(1-sf) and v*(1-sg) multipliers, channel select, byte rounding.
// Every stage has its own valid bit and takes new data when it is empty or the stage
// after it moves, so bubbles close up and a stalled receiver fills the pipeline before
// s_axis_tready_o drops. Nothing is lost or repeated under stall.
// Reset (rst_ni low, asynchronous) clears all valid bits; the pipeline comes up empty.
// Depends on hsvrgb_pkg.
`default_nettype none
module hsv_to_rgb_converter_unit #(
  parameter int unsigned FRAC_BITS = hsvrgb_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                s_axis_tvalid_i,
  output      logic                                s_axis_tready_o,
  // hue[23:0], saturation[47:24], brightness[71:48]
  input  wire logic [hsvrgb_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  output      logic                                m_axis_tvalid_o,
  input  wire logic                                m_axis_tready_i,
  // red[7:0], green[15:8], blue[23:16]
  output      logic [hsvrgb_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o
);
  import hsvrgb_pkg::*;

  localparam int unsigned U      = FRAC_BITS + 1;
  localparam int unsigned PW     = 2 * FRAC_BITS + 1;
  localparam int unsigned NSTG   = 6;
  localparam int unsigned EXT_W  = IN_W + 2;
  localparam logic signed [EXT_W-1:0] ONE_EXT = EXT_W'(1) << FRAC_BITS;
  localparam logic [U-1:0]  ONE_U  = U'(1) << FRAC_BITS;
  localparam logic [PW+7:0] HALF   = (PW + 8)'(1) << (2 * FRAC_BITS - 1);

  typedef enum logic [2:0] {
    SEXT_RY, SEXT_YG, SEXT_GC, SEXT_CB, SEXT_BM, SEXT_MR
  } sext_e;

  function automatic logic [U-1:0] clip_unit(input logic [IN_W-1:0] x);
    logic signed [EXT_W-1:0] ext;
    ext = {{2{x[IN_W-1]}}, x};
    if (x[IN_W-1]) begin
      return '0;
    end else if (ext > ONE_EXT) begin
      return ONE_U;
    end else begin
      return ext[U-1:0];
    end
  endfunction

  function automatic logic [CH_W-1:0] to_byte(input logic [PW-1:0] x);
    logic [PW+7:0] wide;
    wide = {x, 8'b0} - (PW + 8)'(x) + HALF;
    return wide[2*FRAC_BITS+7:2*FRAC_BITS];
  endfunction

  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = ~vld_q[NSTG-1] | m_axis_tready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = ~vld_q[k] | en[k+1];
    end
  end

  assign s_axis_tready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid_i;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // stage 1: wrap hue, clip saturation and value
  logic [FRAC_BITS-1:0] h1_q;
  logic [U-1:0]         s1_q, v1_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      h1_q <= s_axis_tdata_i[FRAC_BITS-1:0];
      s1_q <= clip_unit(s_axis_tdata_i[2*IN_W-1:IN_W]);
      v1_q <= clip_unit(s_axis_tdata_i[3*IN_W-1:2*IN_W]);
    end
  end

  // stage 2: sextant and fraction
  logic [FRAC_BITS+2:0] h6_d;
  sext_e                sext2_q;
  logic [FRAC_BITS-1:0] f2_q;
  logic [U-1:0]         omf2_q, s2_q, v2_q, oms2_q;

  assign h6_d = {1'b0, h1_q, 2'b00} + {2'b00, h1_q, 1'b0};

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sext2_q <= sext_e'(h6_d[FRAC_BITS+2:FRAC_BITS]);
      f2_q    <= h6_d[FRAC_BITS-1:0];
      omf2_q  <= ONE_U - {1'b0, h6_d[FRAC_BITS-1:0]};
      s2_q    <= s1_q;
      v2_q    <= v1_q;
      oms2_q  <= ONE_U - s1_q;
    end
  end

  // stage 3: s*f, s*(1-f), v*(1-s)
  logic [2*U-1:0] sf_prod_d, sg_prod_d, p_prod_d;
  sext_e          sext3_q;
  logic [U-1:0]   sf3_q, sg3_q, v3_q;
  logic [PW-1:0]  p3_q;

  assign sf_prod_d = (2*U)'(s2_q) * (2*U)'(f2_q);
  assign sg_prod_d = (2*U)'(s2_q) * (2*U)'(omf2_q);
  assign p_prod_d  = (2*U)'(v2_q) * (2*U)'(oms2_q);

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      sext3_q <= sext2_q;
      sf3_q   <= sf_prod_d[FRAC_BITS+U-1:FRAC_BITS];
      sg3_q   <= sg_prod_d[FRAC_BITS+U-1:FRAC_BITS];
      p3_q    <= p_prod_d[PW-1:0];
      v3_q    <= v2_q;
    end
  end

  // stage 4: v*(1-sf), v*(1-sg); zero saturation gives p = q = t = v, i.e. gray
  logic [2*U-1:0] q_prod_d, t_prod_d;
  sext_e          sext4_q;
  logic [PW-1:0]  p4_q, q4_q, t4_q, vv4_q;

  assign q_prod_d = (2*U)'(v3_q) * (2*U)'(ONE_U - sf3_q);
  assign t_prod_d = (2*U)'(v3_q) * (2*U)'(ONE_U - sg3_q);

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      sext4_q <= sext3_q;
      p4_q    <= p3_q;
      q4_q    <= q_prod_d[PW-1:0];
      t4_q    <= t_prod_d[PW-1:0];
      vv4_q   <= PW'(v3_q) << FRAC_BITS;
    end
  end

  // stage 5: channel select
  logic [PW-1:0] r_d, g_d, b_d;
  logic [PW-1:0] r5_q, g5_q, b5_q;

  always_comb begin
    case (sext4_q)
      SEXT_RY: begin r_d = vv4_q; g_d = t4_q;  b_d = p4_q;  end
      SEXT_YG: begin r_d = q4_q;  g_d = vv4_q; b_d = p4_q;  end
      SEXT_GC: begin r_d = p4_q;  g_d = vv4_q; b_d = t4_q;  end
      SEXT_CB: begin r_d = p4_q;  g_d = q4_q;  b_d = vv4_q; end
      SEXT_BM: begin r_d = t4_q;  g_d = p4_q;  b_d = vv4_q; end
      default: begin r_d = vv4_q; g_d = p4_q;  b_d = q4_q;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      r5_q <= r_d;
      g5_q <= g_d;
      b5_q <= b_d;
    end
  end

  // stage 6: round to bytes
  logic [OUT_TDATA_W-1:0] out_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      out_q <= {to_byte(b5_q), to_byte(g5_q), to_byte(r5_q)};
    end
  end

  assign m_axis_tdata_o  = out_q;
  assign m_axis_tvalid_o = vld_q[NSTG-1];

  a_full_on_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i && (&vld_q)))
    else $error("input stalled while pipeline can move");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> vld_q[0])
    else $error("accepted request not captured in first stage");

  a_terms_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[3] |-> (p4_q <= vv4_q && q4_q <= vv4_q && t4_q <= vv4_q))
    else $error("channel term above value level");

  a_out_from_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(vld_q[NSTG-2]))
    else $error("result appeared without a request behind it");

endmodule
`default_nettype wire

// ----- tb/hsv_rgb_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for hsv_to_rgb_converter_unit: watches both request channels, predicts
// each color from its HSV request and compares the bytes in arrival order.
// Depends on hsvrgb_pkg for field widths and the fraction width.
module hsv_rgb_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_tvalid_i,
  input  logic                               s_tready_i,
  // hue[23:0], saturation[47:24], brightness[71:48]
  input  logic [hsvrgb_pkg::IN_TDATA_W-1:0]  s_tdata_i,
  input  logic                               m_tvalid_i,
  input  logic                               m_tready_i,
  // red[7:0], green[15:8], blue[23:16]
  input  logic [hsvrgb_pkg::OUT_TDATA_W-1:0] m_tdata_i,
  output int unsigned                        fail_count_o,
  output int unsigned                        pending_o,
  output int unsigned                        checked_o
);
  import hsvrgb_pkg::*;

  localparam int unsigned FB          = FRAC_BITS_DEF;
  localparam logic [63:0] UNIT        = 64'd1 << FB;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic [2:0] {
    SEXT_RED_YELLOW,
    SEXT_YELLOW_GREEN,
    SEXT_GREEN_CYAN,
    SEXT_CYAN_BLUE,
    SEXT_BLUE_MAGENTA,
    SEXT_MAGENTA_RED
  } hue_sextant_e;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } rgb_t;

  typedef struct {
    logic [IN_W-1:0] hue;
    logic [IN_W-1:0] sat;
    logic [IN_W-1:0] bri;
    rgb_t            rgb;
  } color_expect_t;

  color_expect_t expected_rgb_q[$];
  color_expect_t head;
  rgb_t          got;
  int unsigned   fail_count = 0;
  int unsigned   checked    = 0;

  function automatic logic [63:0] clip_level(input logic [IN_W-1:0] x);
    if (x[IN_W-1]) return 64'd0;
    if (64'(x) > UNIT) return UNIT;
    return 64'(x);
  endfunction

  function automatic logic [CH_W-1:0] round_byte(input logic [63:0] x);
    logic [63:0] scaled;
    scaled = x * 64'd255 + (64'd1 << (2 * FB - 1));
    return scaled[2*FB +: CH_W];
  endfunction

  function automatic rgb_t hsv_to_rgb(input logic [IN_W-1:0] hue, sat, bri);
    logic [63:0]  h, s, v, vv, h6, f, sf, sg, p, q, t, r, g, b;
    hue_sextant_e sext;
    rgb_t         res;
    h  = 64'(hue[FB-1:0]);  // wrap to one turn
    s  = clip_level(sat);
    v  = clip_level(bri);
    vv = v << FB;
    r  = vv;
    g  = vv;
    b  = vv;
    if (s != 64'd0) begin
      h6   = h * 64'd6;
      sext = hue_sextant_e'(h6[FB+2:FB]);
      f    = h6 & (UNIT - 64'd1);
      sf   = (s * f) >> FB;
      sg   = (s * (UNIT - f)) >> FB;
      p    = v * (UNIT - s);
      q    = v * (UNIT - sf);
      t    = v * (UNIT - sg);
      case (sext)
        SEXT_RED_YELLOW: begin
          r = vv; g = t;  b = p;
        end
        SEXT_YELLOW_GREEN: begin
          r = q;  g = vv; b = p;
        end
        SEXT_GREEN_CYAN: begin
          r = p;  g = vv; b = t;
        end
        SEXT_CYAN_BLUE: begin
          r = p;  g = q;  b = vv;
        end
        SEXT_BLUE_MAGENTA: begin
          r = t;  g = p;  b = vv;
        end
        default: begin
          r = vv; g = p;  b = q;
        end
      endcase
    end
    res.red   = round_byte(r);
    res.green = round_byte(g);
    res.blue  = round_byte(b);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_rgb_q.delete();
      pending_o <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        got = rgb_t'(m_tdata_i);
        if (expected_rgb_q.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t: unexpected color r=%h g=%h b=%h", $realtime,
                     got.red, got.green, got.blue);
          fail_count++;
        end else begin
          head = expected_rgb_q.pop_front();
          checked++;
          if (got.red !== head.rgb.red || got.green !== head.rgb.green ||
              got.blue !== head.rgb.blue) begin
            if (fail_count < MAX_REPORTS)
              $display("%0t: hsv %h/%h/%h expected r=%h g=%h b=%h got r=%h g=%h b=%h",
                       $realtime, head.hue, head.sat, head.bri, head.rgb.red,
                       head.rgb.green, head.rgb.blue, got.red, got.green, got.blue);
            fail_count++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        head.hue = s_tdata_i[IN_W-1:0];
        head.sat = s_tdata_i[2*IN_W-1:IN_W];
        head.bri = s_tdata_i[3*IN_W-1:2*IN_W];
        head.rgb = hsv_to_rgb(head.hue, head.sat, head.bri);
        expected_rgb_q.push_back(head);
      end
      pending_o <= expected_rgb_q.size();
    end
  end

  assign fail_count_o = fail_count;
  assign checked_o    = checked;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// Top of the HSV to RGB converter test: clock, reset, pixel stimulus with random
// gaps and output stalls, and the verdict. Needs hsv_rgb_checker and the RTL.
module testbench;
  import hsvrgb_pkg::*;

  localparam logic [IN_W-1:0] UNIT           = 24'h010000;
  localparam int unsigned     LONG_STALL     = 120;
  localparam int unsigned     RAND_PER_PHASE = 150;
  localparam int unsigned     N_PHASES       = 4;

  typedef enum logic [1:0] {IDLE_NONE, IDLE_SOME, IDLE_ANY} idle_mode_e;

  logic                   clk      = 1'b0;
  logic                   rst_n    = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;
  logic                   s_tready;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  int unsigned            fail_count, pending, checked;
  int unsigned            pixels_sent = 0;
  idle_mode_e             send_mode   = IDLE_ANY;
  idle_mode_e             recv_mode   = IDLE_SOME;
  bit                     long_stall_req = 1'b0;

  hsv_to_rgb_converter_unit i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  hsv_rgb_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic int unsigned draw_gap(input idle_mode_e mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_SOME: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
      default:   return $urandom_range(0, 13);
    endcase
  endfunction

  // Saturation or value level: mostly in range, some clipped or extreme.
  function automatic logic [IN_W-1:0] rand_level();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: return IN_W'($urandom_range(0, UNIT));
      6:                return $urandom_range(0, 1) ? UNIT : '0;
      7:                return IN_W'($urandom_range(UNIT + 1, 2 * UNIT));
      8:                return IN_W'(-$urandom_range(1, UNIT));
      default:          return IN_W'($urandom());
    endcase
  endfunction

  task automatic send_pixel(input logic [IN_W-1:0] hue, sat, bri);
    int unsigned gap;
    gap = draw_gap(send_mode);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {bri, sat, hue};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pixels_sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Output side: random stalls per result, one long hold-off on request.
  initial begin
    int unsigned gap;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end
      gap = draw_gap(recv_mode);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  initial begin
    logic [IN_W-1:0] hue;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // hue wrap, sextant edges and midpoints, gray and clipped levels
    send_pixel(24'h000000, UNIT, UNIT);
    send_pixel(24'h002AAA, UNIT, UNIT);
    send_pixel(24'h002AAB, UNIT, UNIT);
    send_pixel(24'h008000, UNIT, UNIT);
    send_pixel(24'h001555, 24'h008000, 24'h00C000);
    send_pixel(24'h004000, 24'h008000, 24'h00C000);
    send_pixel(24'h006AAA, 24'h008000, 24'h00C000);
    send_pixel(24'h009555, 24'h008000, 24'h00C000);
    send_pixel(24'h00C000, 24'h008000, 24'h00C000);
    send_pixel(24'h00EAAA, 24'h008000, 24'h00C000);
    send_pixel(UNIT, UNIT, UNIT);
    send_pixel(24'hFFC000, UNIT, UNIT);
    send_pixel(24'h7FFFFF, 24'h008000, UNIT);
    send_pixel(24'h800000, UNIT, 24'h008000);
    send_pixel(24'h004000, 24'h000000, UNIT);
    send_pixel(24'h004000, 24'hFF0000, 24'h008000);
    send_pixel(24'h00AAAA, 24'h800000, 24'h7FFFFF);
    send_pixel(24'h003000, 24'h7FFFFF, 24'h008000);
    send_pixel(24'h003000, UNIT, 24'hFFFFFF);
    send_pixel(24'h00D000, UNIT, 24'h800000);
    send_pixel(24'h00D000, UNIT, 24'h000000);
    send_pixel(24'h00FFFF, UNIT, UNIT);
    send_pixel(24'h002000, 24'h000001, UNIT);
    send_pixel(24'h005000, 24'h010001, 24'h010001);
    wait_drained();

    for (int unsigned phase = 0; phase < N_PHASES; phase++) begin
      case (phase)
        0: begin
          send_mode = IDLE_ANY;  recv_mode = IDLE_ANY;
        end
        1: begin
          send_mode = IDLE_NONE; recv_mode = IDLE_NONE;
          long_stall_req = 1'b1;
        end
        2: begin
          send_mode = IDLE_SOME; recv_mode = IDLE_ANY;
        end
        default: begin
          send_mode = IDLE_ANY;  recv_mode = IDLE_SOME;
        end
      endcase
      repeat (RAND_PER_PHASE) begin
        hue = ($urandom_range(0, 9) < 7) ? IN_W'($urandom_range(0, UNIT - 1))
                                         : IN_W'($urandom());
        send_pixel(hue, rand_level(), rand_level());
      end
      wait_drained();
    end

    repeat (12) @(posedge clk);
    $display("Converted %0d pixels and checked %0d colors: hue wrap, sextant edges,",
             pixels_sent, checked);
    $display("gray and clipped levels, random gaps both ways, a %0d-cycle output stall",
             LONG_STALL);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- hsv_to_rgb_converter_unit.f -----
src/hsvrgb_pkg.sv
src/hsv_to_rgb_converter_unit.sv
tb/hsv_rgb_checker.sv
tb/testbench.sv
